// ----- hdl/osa_pkg.sv -----
// Shared types, constants and packing function for the octal float add/subtract block.
package osa_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHL,
		ST_SHR,
		ST_ARITH,
		ST_NORM,
		ST_ROUND,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic zero;
		logic e_ne;
		logic shl_step;
		logic shr_step;
		logic shr_stop;
		logic norm_enter;
		logic norm_step;
	} dp_stat_t;

	localparam int WORD_W = 48;
	localparam int MANT_W = 39;
	localparam int WIDE_W = 44;
	localparam int EXP_W = 8;
	localparam logic signed [EXP_W-1:0] EXP_MIN = -8'sd63;
	localparam logic signed [EXP_W-1:0] EXP_MAX = 8'sd63;

	function automatic logic [WORD_W-1:0] pack_word(input logic nz, input logic s,
			input logic signed [EXP_W-1:0] e, input logic [MANT_W-1:0] m);
		logic [6:0] mag;
		logic [WORD_W-1:0] w;
		mag = e[7] ? 7'(-e) : e[6:0];
		w = '0;
		if (nz) begin
			w[38:0] = m;
			w[46] = s;
			w[45:39] = mag;
			if (e[7]) begin
				w[45] = 1'b1;
			end
		end
		return w;
	endfunction

endpackage

// ----- hdl/osa_ctrl.sv -----
// Sequencer for the digit-serial align, add, normalize and round steps.
module osa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              out_busy,
	input  osa_pkg::dp_stat_t stat,
	output osa_pkg::state_t   st,
	output logic              in_stall,
	output logic              deliver
);
	import osa_pkg::*;

	state_t st_q;
	state_t st_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_nxt;
		end
	end

	always_comb begin
		st_nxt = st_q;
		case (st_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (stat.zero) begin
						st_nxt = ST_DONE;
					end else if (stat.e_ne) begin
						st_nxt = ST_SHL;
					end else begin
						st_nxt = ST_ARITH;
					end
				end
			end
			ST_SHL: begin
				if (!stat.shl_step) begin
					st_nxt = ST_SHR;
				end
			end
			ST_SHR: begin
				if (!stat.shr_step || stat.shr_stop) begin
					st_nxt = ST_ARITH;
				end
			end
			ST_ARITH: begin
				st_nxt = stat.norm_enter ? ST_NORM : ST_ROUND;
			end
			ST_NORM: begin
				if (!stat.norm_step) begin
					st_nxt = ST_ROUND;
				end
			end
			ST_ROUND: begin
				st_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (!out_busy) begin
					st_nxt = ST_IDLE;
				end
			end
			default: begin
				st_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		st = st_q;
		in_stall = (st_q != ST_IDLE);
		deliver = (st_q == ST_DONE) && !out_busy;
	end

endmodule

// ----- hdl/osa_dp.sv -----
// Operand shift registers and digit-step arithmetic for the octal float add/subtract.
module osa_dp (
	input  logic                      clk,
	input  osa_pkg::state_t           st,
	input  logic                      load,
	input  logic                      emode,
	input  logic                      req_type,
	input  logic [47:0]               a_word,
	input  logic [47:0]               b_word,
	input  logic                      normal_state,
	output osa_pkg::dp_stat_t         stat,
	output logic [47:0]               res_word,
	output logic [38:0]               res_ext,
	output logic                      res_irq
);
	import osa_pkg::*;

	logic [MANT_W-1:0] am_q, ax_q, bx_q;
	logic [WIDE_W-1:0] bm_q;
	logic signed [EXP_W-1:0] ae_q, be_q;
	logic as_q, bs_q, sel_q, nst_q;

	logic [MANT_W-1:0] ua_m, ub_m;
	logic signed [EXP_W-1:0] ua_e, ub_e;
	logic ua_s, ub_s;
	logic [47:0] zero_word;

	logic [MANT_W-1:0] big_m, big_x, sm_m, sm_x;
	logic signed [EXP_W-1:0] big_e, sm_e, sm_e_inc;
	logic [MANT_W-1:0] shl_m, shl_x, shr_m, shr_x;

	logic [MANT_W:0] xs, ms, xd;
	logic [MANT_W-1:0] ar_x;
	logic [WIDE_W-1:0] ar_m;
	logic signed [EXP_W-1:0] ar_e;
	logic ar_s, b_gt;

	logic [WIDE_W-1:0] r_m, m1, mp;
	logic [MANT_W-1:0] r_x, x1;
	logic signed [EXP_W-1:0] r_e, e1, f_e;
	logic r_irq;

	always_comb begin
		ua_m = a_word[38:0];
		ub_m = b_word[38:0];
		ua_e = a_word[45] ? -$signed({2'b00, a_word[44:39]}) : $signed({2'b00, a_word[44:39]});
		ub_e = b_word[45] ? -$signed({2'b00, b_word[44:39]}) : $signed({2'b00, b_word[44:39]});
		ua_s = a_word[46];
		ub_s = b_word[46];
		if (ua_m == '0) begin
			ua_e = '0;
			ua_s = 1'b0;
		end
		if (ub_m == '0) begin
			ub_e = '0;
			ub_s = 1'b0;
		end
		ua_s = ua_s ^ req_type;
		if (ua_m == '0) begin
			zero_word = {1'b0, b_word[46:0]};
		end else begin
			zero_word = pack_word(1'b1, ua_s, ua_e, ua_m);
		end
	end

	always_comb begin
		big_m = sel_q ? am_q : bm_q[38:0];
		big_x = sel_q ? ax_q : bx_q;
		big_e = sel_q ? ae_q : be_q;
		sm_m = sel_q ? bm_q[38:0] : am_q;
		sm_x = sel_q ? bx_q : ax_q;
		sm_e = sel_q ? be_q : ae_q;
		shl_m = {big_m[35:0], big_x[38:36]};
		shl_x = {big_x[35:0], 3'b000};
		shr_m = {3'b000, sm_m[38:3]};
		shr_x = {sm_m[2:0], sm_x[38:3]};
		sm_e_inc = sm_e + 8'sd1;
	end

	always_comb begin
		xs = {1'b0, bx_q} + {1'b0, ax_q};
		ms = {1'b0, bm_q[38:0]} + {1'b0, am_q} + {39'd0, xs[39]};
		b_gt = bm_q[38:0] > am_q;
		xd = '0;
		ar_s = bs_q;
		ar_e = be_q;
		if (as_q == bs_q) begin
			if (ms[39]) begin
				ar_m = {7'd0, ms[39:3]};
				ar_x = {ms[2:0], xs[38:3]};
				ar_e = be_q + 8'sd1;
			end else begin
				ar_m = {4'd0, ms};
				ar_x = xs[38:0];
			end
		end else if (b_gt) begin
			xd = {1'b0, bx_q} - {1'b0, ax_q};
			ar_x = xd[38:0];
			ar_m = {5'd0, bm_q[38:0] - am_q - {38'd0, xd[39]}};
		end else begin
			xd = {1'b0, ax_q} - {1'b0, bx_q};
			ar_x = xd[38:0];
			ar_m = {4'd0, {1'b0, am_q} - {39'd0, xd[39]} - {1'b0, bm_q[38:0]}};
			ar_s = !bs_q;
		end
	end

	always_comb begin
		r_m = bm_q;
		r_x = bx_q;
		r_e = be_q;
		m1 = bm_q;
		x1 = bx_q;
		e1 = be_q;
		mp = bm_q + 44'd1;
		if (emode) begin
			if (bx_q[38]) begin
				if (bm_q[38:36] == 3'b000) begin
					r_m = {bm_q[40:0], bx_q[38:36]};
					r_x = {bx_q[35:0], 3'b000};
					r_e = be_q - 8'sd1;
				end else if (mp[39]) begin
					r_m = {3'b000, mp[43:3]};
					r_x = {mp[2:0], bx_q[38:3]};
					r_e = be_q + 8'sd1;
				end else begin
					r_m = mp;
				end
			end
		end else if (bx_q[38:36] != 3'b000) begin
			if (bm_q[38:36] == 3'b000) begin
				m1 = {bm_q[40:0], bx_q[38:36]};
				x1 = {bx_q[35:0], 3'b000};
				e1 = be_q - 8'sd1;
			end
			r_m = m1;
			r_x = x1;
			r_e = e1;
			if (x1[38] && (m1[38:0] != '1)) begin
				r_m = m1 + 44'd1;
			end
		end
		f_e = r_e;
		r_irq = 1'b0;
		if (r_e > EXP_MAX) begin
			f_e = {2'b00, r_e[5:0]};
			r_irq = nst_q;
		end
	end

	always_comb begin
		stat.zero = (ua_m == '0) || (ub_m == '0);
		stat.e_ne = (ua_e != ub_e);
		stat.shl_step = (big_m[38:36] == 3'b000) && (big_e > sm_e);
		stat.shr_step = sm_e < big_e;
		stat.shr_stop = !emode && (shr_m == '0) && (sm_e_inc != big_e);
		stat.norm_enter = emode && (ar_e != '0);
		stat.norm_step = (bm_q[38:36] == 3'b000) && (be_q > EXP_MIN);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			am_q <= ua_m;
			ax_q <= '0;
			ae_q <= ua_e;
			as_q <= ua_s;
			bm_q <= {5'd0, ub_m};
			bx_q <= '0;
			be_q <= ub_e;
			bs_q <= ub_s;
			sel_q <= ua_e > ub_e;
			nst_q <= normal_state;
			res_word <= zero_word;
			res_ext <= '0;
			res_irq <= 1'b0;
		end else begin
			case (st)
				ST_SHL: begin
					if (stat.shl_step) begin
						if (sel_q) begin
							am_q <= shl_m;
							ax_q <= shl_x;
							ae_q <= big_e - 8'sd1;
						end else begin
							bm_q <= {5'd0, shl_m};
							bx_q <= shl_x;
							be_q <= big_e - 8'sd1;
						end
					end
				end
				ST_SHR: begin
					if (stat.shr_step) begin
						if (sel_q) begin
							bm_q <= {5'd0, shr_m};
							bx_q <= stat.shr_stop ? '0 : shr_x;
							be_q <= stat.shr_stop ? big_e : sm_e_inc;
						end else begin
							am_q <= shr_m;
							ax_q <= stat.shr_stop ? '0 : shr_x;
							ae_q <= stat.shr_stop ? big_e : sm_e_inc;
						end
					end
				end
				ST_ARITH: begin
					bm_q <= ar_m;
					bx_q <= ar_x;
					be_q <= ar_e;
					bs_q <= ar_s;
				end
				ST_NORM: begin
					if (stat.norm_step) begin
						bm_q <= {5'd0, bm_q[35:0], bx_q[38:36]};
						bx_q <= {bx_q[35:0], 3'b000};
						be_q <= be_q - 8'sd1;
					end
				end
				ST_ROUND: begin
					res_word <= pack_word(r_m != '0, bs_q, f_e, r_m[38:0]);
					res_ext <= r_x;
					res_irq <= r_irq;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- hdl/octal_float_add_subtract.sv -----
// Top level of the base-8 48-bit floating add/subtract block.
//
//   channel  direction  handshake              payload
//   cfg      in         cfg_valid/cfg_ready    extended_mode
//   in       in         in_valid/in_stall      req_type, a_word, b_word, normal_state
//   out      out        out_valid/out_stall    result_word, extension, overflow_irq
//
// One item at a time. A zero operand goes straight to the output register; otherwise the
// item runs the left shift and right shift steps when the exponents differ (right scaling
// stops early on a zero mantissa outside extended mode), then the add/subtract step, the
// normalize steps when the extended-mode normalize runs, and the round step. The shift
// steps move the operand registers one octal digit per cycle.
// arst_n clears the sequencer, the output valid and extended_mode.
// in_stall is high from acceptance until the result moves into the output register; a
// stalled output holds its beat while the next item is taken and worked on.
module octal_float_add_subtract (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        extended_mode,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        req_type,
	input  logic [47:0] a_word,
	input  logic [47:0] b_word,
	input  logic        normal_state,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [47:0] result_word,
	output logic [38:0] extension,
	output logic        overflow_irq
);
	import osa_pkg::*;

	logic emode_q;
	logic out_valid_q;
	logic [47:0] word_q;
	logic [38:0] ext_q;
	logic irq_q;
	logic out_busy, deliver, load;
	state_t st;
	dp_stat_t stat;
	logic [47:0] res_word;
	logic [38:0] res_ext;
	logic res_irq;

	assign cfg_ready = 1'b1;
	assign out_busy = out_valid_q && out_stall;
	assign load = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			emode_q <= extended_mode;
		end
	end

	osa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_busy (out_busy),
		.stat     (stat),
		.st       (st),
		.in_stall (in_stall),
		.deliver  (deliver)
	);

	osa_dp u_dp (
		.clk          (clk),
		.st           (st),
		.load         (load),
		.emode        (emode_q),
		.req_type     (req_type),
		.a_word       (a_word),
		.b_word       (b_word),
		.normal_state (normal_state),
		.stat         (stat),
		.res_word     (res_word),
		.res_ext      (res_ext),
		.res_irq      (res_irq)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (deliver) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (deliver) begin
			word_q <= res_word;
			ext_q <= res_ext;
			irq_q <= res_irq;
		end
	end

	assign out_valid = out_valid_q;
	assign result_word = word_q;
	assign extension = ext_q;
	assign overflow_irq = irq_q;

endmodule

// ----- hdl/osa_chk.sv -----
// Port-level checker for the octal float add/subtract block, with its bind.
module osa_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [47:0] result_word,
	input logic        overflow_irq
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("stalled output beat dropped");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(result_word))
		else $error("stalled output beat changed");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while an item is in work");

	a_flag_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !result_word[47])
		else $error("flag bit set in result");

	a_irq_exp_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow_irq |-> !result_word[45])
		else $error("overflow with negative exponent");

endmodule

bind octal_float_add_subtract osa_chk u_chk (.*);

// ----- tb/octal_float_add_subtract_test.sv -----
// Self-checking testbench for the base-8 48-bit floating add/subtract block.
module octal_float_add_subtract_test;
	import osa_pkg::*;

	localparam logic [63:0] MASK39 = 64'h7F_FFFF_FFFF;
	localparam logic [63:0] TOP_DIGIT = 64'h7 << 36;
	localparam logic [63:0] HI_BIT = 64'h1 << 38;
	localparam logic [63:0] CARRY = 64'h1 << 39;
	localparam int EXP_LO = -63;
	localparam int EXP_HI = 63;
	localparam int HOLD_CYCLES = 400;
	localparam logic OP_ADD = 1'b0;
	localparam logic OP_SUB = 1'b1;

	typedef struct {
		logic [63:0] m;
		logic [63:0] x;
		int e;
		bit s;
	} onum_t;

	typedef struct {
		logic [47:0] word;
		logic [38:0] ext;
		logic irq;
	} osa_res_t;

	typedef struct {
		logic op;
		logic [47:0] a;
		logic [47:0] b;
		logic ns;
		bit typed;
		logic [47:0] word;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic extended_mode = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic req_type = 1'b0;
	logic [47:0] a_word = '0;
	logic [47:0] b_word = '0;
	logic normal_state = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [47:0] result_word;
	logic [38:0] extension;
	logic overflow_irq;

	osa_res_t sum_queue[$];
	stim_row_t stim_tab[$];
	bit emode = 1'b0;
	bit hold_req = 1'b0;
	int errors = 0;
	int n_items = 0;
	int n_results = 0;

	octal_float_add_subtract u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .extended_mode(extended_mode),
		.in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
		.a_word(a_word), .b_word(b_word), .normal_state(normal_state),
		.out_valid(out_valid), .out_stall(out_stall), .result_word(result_word),
		.extension(extension), .overflow_irq(overflow_irq)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic onum_t unpack_o(logic [47:0] w);
		onum_t n;
		n.m = {25'b0, w[38:0]};
		n.x = '0;
		n.e = 0;
		n.s = 1'b0;
		if (n.m != 0) begin
			n.s = w[46];
			n.e = int'(w[44:39]);
			if (w[45])
				n.e = -n.e;
		end
		return n;
	endfunction

	function automatic logic [47:0] pack_o(onum_t n);
		logic [63:0] w;
		if (n.m == 0)
			return '0;
		w = n.m & MASK39;
		if (n.s)
			w[46] = 1'b1;
		if (n.e >= 0)
			w = w | (64'(n.e) << 39);
		else
			w = w | (64'(-n.e) << 39) | (64'h1 << 45);
		return w[47:0];
	endfunction

	function automatic onum_t shl1(onum_t n);
		n.m = (n.m << 3) | (n.x >> 36);
		n.x = (n.x << 3) & MASK39;
		n.e--;
		return n;
	endfunction

	function automatic onum_t shr1(onum_t n);
		n.x = (n.x >> 3) | ((n.m & 64'h7) << 36);
		n.m = n.m >> 3;
		n.e++;
		return n;
	endfunction

	function automatic onum_t norm_left(onum_t n, int target);
		while ((n.m & TOP_DIGIT) == 0 && n.e > target) begin
			n.m = ((n.m << 3) & MASK39) | (n.x >> 36);
			n.x = (n.x << 3) & MASK39;
			n.e--;
		end
		return n;
	endfunction

	function automatic onum_t scale_right(onum_t n, int target, bit em);
		while (n.e < target) begin
			n = shr1(n);
			if (!em && n.m == 0 && n.e != target) begin
				n.e = target;
				n.x = '0;
				break;
			end
		end
		return n;
	endfunction

	function automatic osa_res_t predict_sum(logic op, logic [47:0] aw, logic [47:0] bw,
			logic ns, bit em);
		onum_t a;
		onum_t b;
		osa_res_t r;
		a = unpack_o(aw);
		b = unpack_o(bw);
		if (op == OP_SUB)
			a.s = ~a.s;
		r.ext = '0;
		r.irq = 1'b0;
		if (a.m == 0) begin
			r.word = {1'b0, bw[46:0]};
			return r;
		end
		if (b.m == 0) begin
			r.word = pack_o(a);
			return r;
		end
		if (a.e > b.e) begin
			a = norm_left(a, b.e);
			b = scale_right(b, a.e, em);
		end else if (a.e < b.e) begin
			b = norm_left(b, a.e);
			a = scale_right(a, b.e, em);
		end
		if (a.s == b.s) begin
			b.x = b.x + a.x;
			b.m = b.m + (b.x >> 39);
			b.x = b.x & MASK39;
			b.m = b.m + a.m;
			if ((b.m & CARRY) != 0)
				b = shr1(b);
		end else if (b.m > a.m) begin
			b.x = b.x - a.x;
			if ((b.x & CARRY) != 0) begin
				b.m = b.m - 1;
				b.x = b.x & MASK39;
			end
			b.m = b.m - a.m;
		end else begin
			b.x = a.x - b.x;
			if ((b.x & CARRY) != 0) begin
				a.m = a.m - 1;
				b.x = b.x & MASK39;
			end
			b.m = (a.m - b.m) & (CARRY | MASK39);
			b.s = ~b.s;
		end
		if (em && b.e != 0)
			b = norm_left(b, EXP_LO);
		if (em) begin
			if ((b.x & HI_BIT) != 0) begin
				if ((b.m & TOP_DIGIT) == 0) begin
					b = shl1(b);
				end else begin
					b.m = b.m + 1;
					if ((b.m & CARRY) != 0)
						b = shr1(b);
				end
			end
		end else if ((b.x & TOP_DIGIT) != 0) begin
			if ((b.m & TOP_DIGIT) == 0)
				b = shl1(b);
			if ((b.x & HI_BIT) != 0 && (b.m & MASK39) != MASK39)
				b.m = b.m + 1;
		end
		if (b.e > EXP_HI) begin
			b.e = b.e & 63;
			r.irq = ns;
		end
		r.word = pack_o(b);
		r.ext = b.x[38:0];
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [47:0] rand_word();
		logic [63:0] m;
		logic [5:0] e;
		case ($urandom_range(0, 7))
			0: m = '0;
			1: m = MASK39;
			2: m = TOP_DIGIT;
			default: m = ({$urandom, $urandom} & MASK39) >> (3 * $urandom_range(0, 12));
		endcase
		if ($urandom_range(0, 2) == 0)
			e = 6'($urandom_range(0, 63));
		else if ($urandom_range(0, 1) == 0)
			e = 6'($urandom_range(60, 63));
		else
			e = 6'($urandom_range(0, 6));
		return {1'($urandom), 1'($urandom), 1'($urandom), e, m[38:0]};
	endfunction

	task automatic add_row(logic op, logic [47:0] a, logic [47:0] b, logic ns, bit typed,
			logic [47:0] word);
		stim_row_t row;
		row.op = op;
		row.a = a;
		row.b = b;
		row.ns = ns;
		row.typed = typed;
		row.word = word;
		stim_tab.push_back(row);
	endtask

	task automatic send_item(logic op, logic [47:0] a, logic [47:0] b, logic ns, bit typed,
			logic [47:0] word);
		osa_res_t r;
		int gap;
		in_valid <= 1'b1;
		req_type <= op;
		a_word <= a;
		b_word <= b;
		normal_state <= ns;
		@(posedge clk);
		while (!(in_valid && !in_stall))
			@(posedge clk);
		if (typed) begin
			r.word = word;
			r.ext = '0;
			r.irq = 1'b0;
		end else begin
			r = predict_sum(op, a, b, ns, emode);
		end
		sum_queue.push_back(r);
		n_items++;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_and_set(bit v);
		in_valid <= 1'b0;
		while (sum_queue.size() != 0)
			@(posedge clk);
		repeat (160) @(posedge clk);
		cfg_valid <= 1'b1;
		extended_mode <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		emode = v;
		@(posedge clk);
	endtask

	// receiver: random stall stretches, plus one long hold-off on request
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				n = pick_gap();
				if (n > 0) begin
					out_stall <= 1'b1;
					repeat (n) @(posedge clk);
				end
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		osa_res_t r;
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			if (sum_queue.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat result_word=%h", $time, result_word);
			end else begin
				r = sum_queue.pop_front();
				if (result_word !== r.word) begin
					errors++;
					$display("%0t: result_word expected %h actual %h", $time, r.word,
						result_word);
				end
				if (extension !== r.ext) begin
					errors++;
					$display("%0t: extension expected %h actual %h", $time, r.ext, extension);
				end
				if (overflow_irq !== r.irq) begin
					errors++;
					$display("%0t: overflow_irq expected %b actual %b", $time, r.irq,
						overflow_irq);
				end
			end
		end
	end

	initial begin
		#60_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int phase;
		int k;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_row(OP_ADD, 48'h0, 48'h0, 1'b1, 1'b1, 48'h0);
		add_row(OP_ADD, 48'h0, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b1, 48'h7FFF_FFFF_FFFF);
		add_row(OP_SUB, 48'h8000_0000_0000, 48'h8123_4000_0000, 1'b1, 1'b1, 48'h0123_4000_0000);
		add_row(OP_SUB, 48'hFFFF_FFFF_FFFF, 48'h0, 1'b0, 1'b0, 48'h0);
		add_row(OP_ADD, 48'hFFFF_FFFF_FFFF, 48'h8000_0000_0000, 1'b1, 1'b0, 48'h0);
		add_row(OP_ADD, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b0, 48'h0);
		add_row(OP_ADD, 48'h1F80_0000_0007, 48'h1F80_0000_0001, 1'b1, 1'b0, 48'h0);
		add_row(OP_ADD, 48'h1FFF_FFFF_FFFF, 48'h1FFF_FFFF_FFFF, 1'b1, 1'b0, 48'h0);
		add_row(OP_ADD, 48'h1FFF_FFFF_FFFF, 48'h1FFF_FFFF_FFFF, 1'b0, 1'b0, 48'h0);
		add_row(OP_SUB, 48'h0123_4567_0123, 48'h0123_4567_0123, 1'b0, 1'b0, 48'h0);
		add_row(OP_ADD, 48'h2000_0000_0005, 48'h0000_0000_0003, 1'b0, 1'b0, 48'h0);
		add_row(OP_ADD, 48'h3F80_0000_0001, 48'h3F80_7000_0000, 1'b0, 1'b0, 48'h0);
		add_row(OP_SUB, 48'h3F80_0000_0001, 48'h3F00_7FFF_FFFF, 1'b1, 1'b0, 48'h0);
		add_row(OP_ADD, 48'h0000_0000_0001, 48'h1F80_0000_0001, 1'b1, 1'b0, 48'h0);
		add_row(OP_ADD, 48'h0080_7777_7777, 48'h0000_4444_4444, 1'b0, 1'b0, 48'h0);
		add_row(OP_SUB, 48'h4100_0000_0001, 48'h0000_0001_0000, 1'b0, 1'b0, 48'h0);
		add_row(OP_ADD, 48'h0180_0000_1234, 48'h4080_5555_5555, 1'b1, 1'b0, 48'h0);
		add_row(OP_SUB, 48'h4000_7FFF_FFFF, 48'h0000_7FFF_FFFE, 1'b0, 1'b0, 48'h0);

		for (phase = 0; phase < 2; phase++) begin
			if (phase == 1)
				drain_and_set(1'b1);
			foreach (stim_tab[i])
				send_item(stim_tab[i].op, stim_tab[i].a, stim_tab[i].b, stim_tab[i].ns,
					stim_tab[i].typed && (phase == 0), stim_tab[i].word);
		end

		for (phase = 0; phase < 4; phase++) begin
			drain_and_set(phase[0]);
			for (k = 0; k < 250; k++) begin
				if (phase == 1 && k == 40)
					hold_req = 1'b1;
				if (phase == 2 && k == 100) begin
					in_valid <= 1'b0;
					while (sum_queue.size() != 0)
						@(posedge clk);
				end
				send_item(1'($urandom), rand_word(), rand_word(), 1'($urandom), 1'b0, 48'h0);
			end
		end

		in_valid <= 1'b0;
		while (sum_queue.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		$display("Covered %0d operations, %0d results, both rounding modes, zero operands,",
			n_items, n_results);
		$display("exponent wrap and a long output hold-off with input backpressure.");
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/osa_pkg.sv
hdl/osa_ctrl.sv
hdl/osa_dp.sv
hdl/octal_float_add_subtract.sv
hdl/osa_chk.sv
tb/octal_float_add_subtract_test.sv
